// ----- rtl/vpbc_pkg.sv -----
// ----------------------------------------------------------------------------
// vpbc_pkg
// Shared constants and types of the sync-pulse framed byte collector.
// ----------------------------------------------------------------------------
package vpbc_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);

    localparam int WIDTH_W   = 16;
    localparam int DATA_W    = 8;
    localparam int BCNT_W    = 6;
    localparam int PCNT_W    = 7;
    localparam int TARGET_W  = 6;
    localparam int RUN_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [WIDTH_W-1:0]  LONG_THR_RST   = 16'd300;
    localparam logic [WIDTH_W-1:0]  SHORT_THR_RST  = 16'd15;
    localparam logic [TARGET_W-1:0] LONG_TGT_RST   = 6'd6;
    localparam logic [PCNT_W-1:0]   SHORT_SKIP_RST = 7'd6;
    localparam logic [PCNT_W-1:0]   SHORT_END_RST  = 7'd19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_THR   = 3'd0,
        REG_SHORT_THR  = 3'd1,
        REG_LONG_TGT   = 3'd2,
        REG_SHORT_SKIP = 3'd3,
        REG_SHORT_END  = 3'd4,
        REG_DETECT     = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        CMD_PULSE = 1'b0,
        CMD_BYTE  = 1'b1
    } command_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_DATA   = 1'b1
    } kind_t;

endpackage

// ----- rtl/vpbc_in_if.sv -----
// ----------------------------------------------------------------------------
// vpbc_in_if
// Event channel: pulse widths and received bytes with error flags.
// ----------------------------------------------------------------------------
interface vpbc_in_if
    import vpbc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                command;
    logic [WIDTH_W-1:0]  pulse_width;
    logic [DATA_W-1:0]   rx_data;
    logic                rx_ready;
    logic                framing_error;
    logic                noise_error;
    logic                overrun_error;

    modport source (
        output valid, command, pulse_width, rx_data, rx_ready,
               framing_error, noise_error, overrun_error,
        input  ready
    );

    modport sink (
        input  valid, command, pulse_width, rx_data, rx_ready,
               framing_error, noise_error, overrun_error,
        output ready
    );
endinterface

// ----- rtl/vpbc_out_if.sv -----
// ----------------------------------------------------------------------------
// vpbc_out_if
// Result channel: status words and flushed data bytes.
// ----------------------------------------------------------------------------
interface vpbc_out_if
    import vpbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [DATA_W-1:0]  out_byte;
    logic               last;
    logic [BCNT_W-1:0]  stored_bytes;
    logic [PCNT_W-1:0]  long_pulses;
    logic [PCNT_W-1:0]  short_pulses;
    logic               armed_flag;
    logic [RUN_W-1:0]   longest_run;
    logic               byte_accepted;
    logic               byte_dropped_full;

    modport source (
        output valid, kind, out_byte, last, stored_bytes, long_pulses,
               short_pulses, armed_flag, longest_run, byte_accepted,
               byte_dropped_full,
        input  ready
    );

    modport sink (
        input  valid, kind, out_byte, last, stored_bytes, long_pulses,
               short_pulses, armed_flag, longest_run, byte_accepted,
               byte_dropped_full,
        output ready
    );
endinterface

// ----- rtl/vblank_pulse_byte_collector_top.sv -----
// ----------------------------------------------------------------------------
// vblank_pulse_byte_collector_top
// Counts sync pulses, captures bytes inside the short pulse window into a
// buffer memory and flushes them as a run at the end of the frame.
// ----------------------------------------------------------------------------
// A status word is registered at the edge that accepts its event, and a new
// event can be taken every cycle while results are drained. A flush of n
// bytes reads each word via the buffer's single read port into a read register
// and registers it as a data word, one word per cycle while results are taken;
// events wait. Reset is asynchronous: counters, flags and registers take their
// defaults; buffer memory keeps its contents, as only written entries are read.
// ----------------------------------------------------------------------------
module vblank_pulse_byte_collector_top
    import vpbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    vpbc_in_if.sink              events,
    vpbc_out_if.source           results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    state_t               state_reg, state_next;

    logic [WIDTH_W-1:0]   long_thr_reg, long_thr_next;
    logic [WIDTH_W-1:0]   short_thr_reg, short_thr_next;
    logic [TARGET_W-1:0]  long_tgt_reg, long_tgt_next;
    logic [PCNT_W-1:0]    short_skip_reg, short_skip_next;
    logic [PCNT_W-1:0]    short_end_reg, short_end_next;
    logic                 detect_reg, detect_next;

    logic [PCNT_W-1:0]    long_cnt_reg, long_cnt_next;
    logic [PCNT_W-1:0]    short_cnt_reg, short_cnt_next;
    logic [BCNT_W-1:0]    byte_cnt_reg, byte_cnt_next;
    logic                 armed_reg, armed_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic [RUN_W-1:0]     max_run_reg, max_run_next;

    logic [BCNT_W-1:0]    flush_n_reg, flush_n_next;
    logic [BCNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                 rd_pend_reg, rd_pend_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [DATA_W-1:0]    out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_acc_reg, out_acc_next;
    logic                 out_drop_reg, out_drop_next;

    logic [DATA_W-1:0]    buf_mem [BUFFER_DEPTH];
    logic [DATA_W-1:0]    mem_rdata_reg;
    logic                 mem_we;
    logic                 mem_re;

    logic                 ev_accept;
    logic                 take;
    logic                 is_long;
    logic                 is_short;
    logic                 at_target;
    logic                 load;
    logic                 flush_go;
    logic [PCNT_W-1:0]    long_inc;
    logic [PCNT_W-1:0]    short_inc;

    assign events.ready = (state_reg == ST_IDLE) && (!out_valid_reg || results.ready);
    assign ev_accept    = events.valid && events.ready;

    assign results.valid             = out_valid_reg;
    assign results.kind              = out_kind_reg;
    assign results.out_byte          = out_byte_reg;
    assign results.last              = out_last_reg;
    assign results.stored_bytes      = byte_cnt_reg;
    assign results.long_pulses       = long_cnt_reg;
    assign results.short_pulses      = short_cnt_reg;
    assign results.armed_flag        = armed_reg;
    assign results.longest_run       = max_run_reg;
    assign results.byte_accepted     = out_acc_reg;
    assign results.byte_dropped_full = out_drop_reg;

    assign is_long   = events.pulse_width > long_thr_reg;
    assign is_short  = events.pulse_width > short_thr_reg;
    assign at_target = long_cnt_reg == {1'b0, long_tgt_reg};
    assign long_inc  = (long_cnt_reg != '1) ? long_cnt_reg + 1'b1 : long_cnt_reg;
    assign short_inc = (short_cnt_reg != '1) ? short_cnt_reg + 1'b1 : short_cnt_reg;
    assign take      = (armed_reg && events.rx_ready && !events.framing_error
                        && !events.noise_error && !events.overrun_error
                        && (byte_cnt_reg != '0))
                    || ((byte_cnt_reg == '0) && at_target)
                    || (armed_reg && events.noise_error);
    assign load      = rd_pend_reg && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next      = state_reg;
        long_thr_next   = long_thr_reg;
        short_thr_next  = short_thr_reg;
        long_tgt_next   = long_tgt_reg;
        short_skip_next = short_skip_reg;
        short_end_next  = short_end_reg;
        detect_next     = detect_reg;
        long_cnt_next   = long_cnt_reg;
        short_cnt_next  = short_cnt_reg;
        byte_cnt_next   = byte_cnt_reg;
        armed_next      = armed_reg;
        run_next        = run_reg;
        max_run_next    = max_run_reg;
        flush_n_next    = flush_n_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pend_next    = rd_pend_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_acc_next    = out_acc_reg;
        out_drop_next   = out_drop_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        flush_go        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (ev_accept)
                begin
                    out_kind_next = KIND_STATUS;
                    out_byte_next = '0;
                    out_last_next = 1'b1;
                    out_acc_next  = 1'b0;
                    out_drop_next = 1'b0;
                    if (events.command == CMD_BYTE)
                    begin
                        if (take)
                        begin
                            if (byte_cnt_reg < BCNT_W'(BUFFER_DEPTH))
                            begin
                                mem_we        = 1'b1;
                                byte_cnt_next = byte_cnt_reg + 1'b1;
                                out_acc_next  = 1'b1;
                            end
                            else
                            begin
                                out_drop_next = 1'b1;
                            end
                        end
                        armed_next = 1'b0;
                    end
                    else if (detect_reg)
                    begin
                        if (is_long)
                        begin
                            if (run_reg != '1)
                            begin
                                run_next = run_reg + 1'b1;
                            end
                        end
                        else if (is_short)
                        begin
                            if (max_run_reg < run_reg)
                            begin
                                max_run_next = run_reg;
                            end
                            run_next = '0;
                        end
                    end
                    else if (is_long)
                    begin
                        short_cnt_next = '0;
                        if (long_inc > {1'b0, long_tgt_reg})
                        begin
                            long_cnt_next = '0;
                            byte_cnt_next = '0;
                        end
                        else
                        begin
                            long_cnt_next = long_inc;
                        end
                    end
                    else if (is_short && at_target)
                    begin
                        short_cnt_next = short_inc;
                        if ((short_inc > short_skip_reg) && (short_inc < short_end_reg))
                        begin
                            armed_next = 1'b1;
                        end
                        else if (short_inc == short_end_reg)
                        begin
                            long_cnt_next  = '0;
                            short_cnt_next = '0;
                            byte_cnt_next  = '0;
                            flush_go       = byte_cnt_reg != '0;
                        end
                    end
                    else
                    begin
                        long_cnt_next  = '0;
                        short_cnt_next = '0;
                        byte_cnt_next  = '0;
                    end

                    if (flush_go)
                    begin
                        state_next   = ST_FLUSH;
                        flush_n_next = byte_cnt_reg;
                        rd_idx_next  = '0;
                        rd_pend_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DATA;
                    out_byte_next  = mem_rdata_reg;
                    out_last_next  = rd_idx_reg == flush_n_reg;
                    out_acc_next   = 1'b0;
                    out_drop_next  = 1'b0;
                    rd_pend_next   = 1'b0;
                    if (rd_idx_reg == flush_n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if ((rd_idx_reg != flush_n_reg) && (!rd_pend_reg || load))
                begin
                    mem_re       = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG_THR:   long_thr_next   = cfg_wdata;
                REG_SHORT_THR:  short_thr_next  = cfg_wdata;
                REG_LONG_TGT:   long_tgt_next   = cfg_wdata[TARGET_W-1:0];
                REG_SHORT_SKIP: short_skip_next = cfg_wdata[PCNT_W-1:0];
                REG_SHORT_END:  short_end_next  = cfg_wdata[PCNT_W-1:0];
                REG_DETECT:
                begin
                    detect_next = cfg_wdata[0];
                    if (cfg_wdata[0])
                    begin
                        max_run_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            long_thr_reg   <= LONG_THR_RST;
            short_thr_reg  <= SHORT_THR_RST;
            long_tgt_reg   <= LONG_TGT_RST;
            short_skip_reg <= SHORT_SKIP_RST;
            short_end_reg  <= SHORT_END_RST;
            detect_reg     <= 1'b0;
            long_cnt_reg   <= '0;
            short_cnt_reg  <= '0;
            byte_cnt_reg   <= '0;
            armed_reg      <= 1'b0;
            run_reg        <= '0;
            max_run_reg    <= '0;
            flush_n_reg    <= '0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_STATUS;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_acc_reg    <= 1'b0;
            out_drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            long_thr_reg   <= long_thr_next;
            short_thr_reg  <= short_thr_next;
            long_tgt_reg   <= long_tgt_next;
            short_skip_reg <= short_skip_next;
            short_end_reg  <= short_end_next;
            detect_reg     <= detect_next;
            long_cnt_reg   <= long_cnt_next;
            short_cnt_reg  <= short_cnt_next;
            byte_cnt_reg   <= byte_cnt_next;
            armed_reg      <= armed_next;
            run_reg        <= run_next;
            max_run_reg    <= max_run_next;
            flush_n_reg    <= flush_n_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_acc_reg    <= out_acc_next;
            out_drop_reg   <= out_drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            buf_mem[byte_cnt_reg[BUF_AW-1:0]] <= events.rx_data;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= buf_mem[rd_idx_reg[BUF_AW-1:0]];
        end
    end

endmodule
